// ===== rtl/core/dfs_fo_pkg.sv =====
// Shared types and constants for the depth-first finish order block.
package dfs_fo_pkg;

   // Fixed field widths of the transaction payloads
   localparam int VTX_W = 5;
   localparam int ROW_W = 32;
   localparam int CNT_W = 6;

   // Vertex count after reset
   localparam logic [CNT_W-1:0] COUNT_RESET = 6'd32;

   // Request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [4:0]       row_index;
      logic [ROW_W-1:0] row_bits;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic             empty_res;
      logic             last;
   } rsp_type;

   // Events from the search engine to the result sequencer
   typedef struct packed {
      logic             finish;   // a vertex turned black
      logic             done;     // run complete
      logic [VTX_W-1:0] vertex;
   } emit_ctl_type;

endpackage

// ===== rtl/core/dfs_fo_emit.sv =====
// Result sequencer: holds one finished vertex back so the final one can carry last.
module dfs_fo_emit
   import dfs_fo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  emit_ctl_type ctl,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic             pend_valid_ff, pend_valid_in;
   logic [VTX_W-1:0] pend_vertex_ff, pend_vertex_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // Release the held vertex when a newer one arrives or the run ends
   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_vertex_in = pend_vertex_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;
      if (ctl.finish) begin
         if (pend_valid_ff) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.vertex    = pend_vertex_ff;
            rsp_data_in.empty_res = 1'b0;
            rsp_data_in.last      = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_vertex_in = ctl.vertex;
      end else if (ctl.done) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.vertex    = pend_valid_ff ? pend_vertex_ff : '0;
         rsp_data_in.empty_res = !pend_valid_ff;
         rsp_data_in.last      = 1'b1;
         pend_valid_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_vertex_ff <= pend_vertex_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/dfs_finish_order_top.sv =====
// Top level of the depth-first finish order (DFS topological sort) block.
//
// Usage: a request transaction is taken when start is high and busy is low.
// kind load writes one adjacency row (row_bits, edge row_index -> j); busy
// stays low, so loads can arrive back to back. kind run starts a depth-first
// search over vertices 0 .. min(vertex_count, MAX_VERTICES)-1 and raises busy
// until the final result is on the result ports.
// Results appear on rsp_data for exactly one cycle with rsp_valid high, one
// per vertex reached, in finish (post) order; the final one has last set. A
// run that orders nothing gives one result with empty_res and last set.
// The final result shows in the same cycle that busy drops low. The scan of
// each adjacency row checks one bit per cycle unless a push or pop breaks in;
// each push adds one adjacency read and each pop a stack read plus an
// adjacency read; every outer vertex costs a read and a check.
// The first result follows the first finished vertex by one vertex, since one
// result is held back to mark last.
// The receiver cannot stall; no result waits on the receiver.
// Reset: vertex_count returns to 32 and control state clears; adjacency rows
// are not cleared. csr_we writes vertex_count; the user must use it only
// while idle, as the block itself does not enforce this.
module dfs_finish_order_top
   import dfs_fo_pkg::*;
#(
   parameter int MAX_VERTICES = 32
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int SW = VW + CW;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_ORD  = 7'b0000010,
      S_OCHK = 7'b0000100,
      S_SCAN = 7'b0001000,
      S_POP  = 7'b0010000,
      S_LOAD = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [CW-1:0]           outer_ff, outer_in;
   logic [CW-1:0]           depth_ff, depth_in;
   logic [VW-1:0]           cur_v_ff, cur_v_in;
   logic [CW-1:0]           cur_j_ff, cur_j_in;
   logic [MAX_VERTICES-1:0] cur_row_ff, cur_row_in;
   logic [MAX_VERTICES-1:0] seen_ff, seen_in;

   // Adjacency memory
   logic [ROW_W-1:0]        adj_mem [MAX_VERTICES];
   logic [ROW_W-1:0]        adj_rdata_ff;
   logic [VW-1:0]           adj_raddr;
   logic                    adj_we;

   // Walk stack memory: frames below the top, {vertex, next column}
   logic [SW-1:0]           stk_mem [MAX_VERTICES];
   logic [SW-1:0]           stk_rdata_ff;
   logic [VW-1:0]           stk_raddr;
   logic [VW-1:0]           stk_waddr;
   logic [SW-1:0]           stk_wdata;
   logic                    stk_we;

   logic [MAX_VERTICES-1:0] row_ext;
   logic [MAX_VERTICES-1:0] lim_mask;
   logic                    row_hit;
   logic                    row_load_ok;
   emit_ctl_type            emit_ctl;

   // Adjacency row widened or trimmed to the vertex range
   for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_row
      if (gi < ROW_W) begin : g_bit
         assign row_ext[gi] = adj_rdata_ff[gi];
      end else begin : g_zero
         assign row_ext[gi] = 1'b0;
      end
   end

   // Columns in use for this run
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         lim_mask[i] = (i < int'(n_ff));
      end
   end

   assign row_hit     = |(row_ext & lim_mask);
   assign row_load_ok = (int'(req_data.row_index) < MAX_VERTICES);
   assign busy        = (state_ff != S_IDLE);

   // Search sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      n_in       = n_ff;
      outer_in   = outer_ff;
      depth_in   = depth_ff;
      cur_v_in   = cur_v_ff;
      cur_j_in   = cur_j_ff;
      cur_row_in = cur_row_ff;
      seen_in    = seen_ff;
      adj_raddr  = outer_ff[VW-1:0];
      adj_we     = 1'b0;
      stk_raddr  = '0;
      stk_waddr  = '0;
      stk_wdata  = {cur_v_ff, cur_j_ff + CW'(1)};
      stk_we     = 1'b0;
      emit_ctl   = '0;
      emit_ctl.vertex = VTX_W'(cur_v_ff);

      if (csr_we) begin
         count_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.kind == KIND_RUN) begin
                  n_in     = (int'(count_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                             : CW'(count_ff);
                  seen_in  = '0;
                  outer_in = '0;
                  depth_in = '0;
                  state_in = S_ORD;
               end else begin
                  adj_we = row_load_ok;
               end
            end
         end
         S_ORD: begin
            if (outer_ff == n_ff) begin
               state_in = S_DONE;
            end else begin
               adj_raddr = outer_ff[VW-1:0];
               state_in  = S_OCHK;
            end
         end
         S_OCHK: begin
            if (row_hit && !seen_ff[outer_ff[VW-1:0]]) begin
               seen_in[outer_ff[VW-1:0]] = 1'b1;
               cur_v_in   = outer_ff[VW-1:0];
               cur_j_in   = '0;
               cur_row_in = row_ext;
               depth_in   = CW'(1);
               state_in   = S_SCAN;
            end else begin
               outer_in = outer_ff + CW'(1);
               state_in = S_ORD;
            end
         end
         S_SCAN: begin
            if (cur_j_ff == n_ff) begin
               // Top vertex finished: emit and pop
               emit_ctl.finish = 1'b1;
               depth_in        = depth_ff - CW'(1);
               if (depth_ff == CW'(1)) begin
                  outer_in = outer_ff + CW'(1);
                  state_in = S_ORD;
               end else begin
                  stk_raddr = VW'(depth_ff - CW'(2));
                  state_in  = S_POP;
               end
            end else if (cur_row_ff[cur_j_ff[VW-1:0]] && !seen_ff[cur_j_ff[VW-1:0]]) begin
               seen_in[cur_j_ff[VW-1:0]] = 1'b1;
               if (int'(depth_ff) != MAX_VERTICES) begin
                  // Push: park current frame, descend into the new vertex
                  stk_we    = 1'b1;
                  stk_waddr = VW'(depth_ff - CW'(1));
                  cur_v_in  = cur_j_ff[VW-1:0];
                  cur_j_in  = '0;
                  depth_in  = depth_ff + CW'(1);
                  adj_raddr = cur_j_ff[VW-1:0];
                  state_in  = S_LOAD;
               end else begin
                  cur_j_in = cur_j_ff + CW'(1);
               end
            end else begin
               cur_j_in = cur_j_ff + CW'(1);
            end
         end
         S_POP: begin
            cur_v_in  = stk_rdata_ff[SW-1:CW];
            cur_j_in  = stk_rdata_ff[CW-1:0];
            adj_raddr = stk_rdata_ff[SW-1:CW];
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cur_row_in = row_ext;
            state_in   = S_SCAN;
         end
         S_DONE: begin
            emit_ctl.done = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= COUNT_RESET;
         outer_ff <= '0;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         outer_ff <= outer_in;
         depth_ff <= depth_in;
      end
   end

   // Working registers, set before use in every run
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      cur_v_ff   <= cur_v_in;
      cur_j_ff   <= cur_j_in;
      cur_row_ff <= cur_row_in;
      seen_ff    <= seen_in;
   end

   // Adjacency memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[VW'(req_data.row_index)] <= req_data.row_bits;
      end
      adj_rdata_ff <= adj_mem[adj_raddr];
   end

   // Walk stack memory; push and pop never fall in the same cycle
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   dfs_fo_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (emit_ctl),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/dfs_finish_order_tb.sv =====
// Self-checking testbench for the depth-first finish order block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dfs_fo_pkg::*;

   localparam int ITEM_TARGET = 410;
   localparam int CALM_ITEMS  = 40;

   // Vertex marks of the search
   typedef enum logic [1:0] {MARK_WHITE, MARK_GREY, MARK_BLACK} mark_type;

   // Shapes of generated adjacency rows
   typedef enum int unsigned {
      ROW_RANDOM, ROW_SPARSE, ROW_FORWARD, ROW_CHAIN, ROW_NONE, ROW_ALL
   } row_style_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;

   // Mirror of the block state and expected finish order
   logic [ROW_W-1:0] adj_shadow [32];
   logic [CNT_W-1:0] count_shadow = COUNT_RESET;
   rsp_type          finish_q [$];
   int               errors = 0;
   int               sent = 0;
   bit               calm = 1'b1;

   dfs_finish_order_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Depth-first search over the mirrored rows; queues vertices in finish order
   function automatic void predict_finish_order();
      mark_type    mark [32];
      int unsigned stk_vtx [32];
      int unsigned stk_next [32];
      int unsigned order [32];
      logic [31:0] live;
      int unsigned n, depth, v, j, found, root, k;
      rsp_type     item;
      n = (count_shadow > 32) ? 32 : count_shadow;
      live = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      found = 0;
      depth = 0;
      foreach (mark[i]) mark[i] = MARK_WHITE;
      for (root = 0; root < n; root++) begin
         if ((adj_shadow[root] & live) == 32'd0 || mark[root] != MARK_WHITE) continue;
         mark[root] = MARK_GREY;
         stk_vtx[0] = root;
         stk_next[0] = 0;
         depth = 1;
         while (depth > 0) begin
            v = stk_vtx[depth-1];
            j = stk_next[depth-1];
            while (j < n && !(adj_shadow[v][j] && mark[j] == MARK_WHITE)) j++;
            if (j < n) begin
               // descend into the first white successor
               stk_next[depth-1] = j + 1;
               mark[j] = MARK_GREY;
               stk_vtx[depth] = j;
               stk_next[depth] = 0;
               depth++;
            end else begin
               // no white successor left: vertex finishes
               mark[v] = MARK_BLACK;
               depth--;
               order[found] = v;
               found++;
            end
         end
      end
      if (found == 0) begin
         item.vertex = '0;
         item.empty_res = 1'b1;
         item.last = 1'b1;
         finish_q.push_back(item);
      end else begin
         for (k = 0; k < found; k++) begin
            item.vertex = VTX_W'(order[k]);
            item.empty_res = 1'b0;
            item.last = (k == found - 1);
            finish_q.push_back(item);
         end
      end
   endfunction

   function automatic req_type load_item(int unsigned src, logic [ROW_W-1:0] bits);
      req_type item;
      item.kind = KIND_LOAD;
      item.row_index = 5'(src);
      item.row_bits = bits;
      return item;
   endfunction

   function automatic req_type run_item();
      req_type item;
      item.kind = KIND_RUN;
      item.row_index = 5'($urandom_range(31, 0));
      item.row_bits = $urandom;
      return item;
   endfunction

   function automatic logic [31:0] make_row(row_style_type style, int unsigned src,
                                            int unsigned n);
      logic [31:0] live, bits;
      live = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      bits = '0;
      case (style)
         ROW_RANDOM: bits = $urandom;
         ROW_SPARSE: begin
            // a couple of edges in range plus noise beyond the count
            if (n > 0) repeat (2) bits[$urandom_range(n - 1, 0)] = 1'b1;
            bits = bits | ($urandom & ~live);
         end
         ROW_FORWARD: bits = $urandom & live & ~((32'd2 << src) - 32'd1);
         ROW_CHAIN: bits = (src + 1 < n) ? (32'd1 << (src + 1)) : 32'd0;
         ROW_NONE: bits = '0;
         default: bits = '1;
      endcase
      return bits;
   endfunction

   // Drive one transaction and hold it until taken; start stays high on return
   task automatic send_item(input req_type item);
      if (!calm && $urandom_range(3, 0) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(10, 1)) @(negedge clock);
      end
      start = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      if (item.kind == KIND_RUN) predict_finish_order();
      else adj_shadow[item.row_index] = item.row_bits;
      sent++;
      if (sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      @(negedge clock);
   endtask

   // Hold off until all results are in and the engine is done
   task automatic wait_idle();
      start = 1'b0;
      while (finish_q.size() != 0) @(negedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_vertex_count(input logic [CNT_W-1:0] value);
      wait_idle();
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      count_shadow = value;
   endtask

   task automatic test_row_loads();
      for (int unsigned src = 0; src < 32; src++) send_item(load_item(src, $urandom));
   endtask

   task automatic test_reset_count_run();
      send_item(run_item());
   endtask

   // No vertices, then only edges beyond the count
   task automatic test_empty_runs();
      set_vertex_count(6'd0);
      send_item(run_item());
      set_vertex_count(6'd2);
      send_item(load_item(0, 32'hFFFF_FFFC));
      send_item(load_item(1, 32'h8000_0000));
      send_item(run_item());
   endtask

   task automatic test_self_loop();
      set_vertex_count(6'd1);
      send_item(load_item(0, 32'h0000_0001));
      send_item(run_item());
   endtask

   // Chain with a back edge to a grey vertex: finishes in reverse
   task automatic test_chain_order();
      set_vertex_count(6'd5);
      for (int unsigned src = 0; src < 4; src++)
         send_item(load_item(src, 32'd1 << (src + 1)));
      send_item(load_item(4, 32'h0000_0001));
      send_item(run_item());
   endtask

   task automatic test_dense_graph();
      set_vertex_count(6'd4);
      for (int unsigned src = 0; src < 4; src++) send_item(load_item(src, '1));
      send_item(run_item());
   endtask

   task automatic test_count_saturation();
      set_vertex_count(6'd63);
      send_item(run_item());
   endtask

   // Mostly complete graphs of random shape, some stray loads and reruns
   task automatic test_random_graphs();
      int unsigned   pick, cnt, n, runs, src;
      row_style_type style;
      calm = 1'b0;
      while (sent < ITEM_TARGET) begin
         pick = $urandom_range(99, 0);
         if (pick < 5) cnt = 32;
         else if (pick < 8) cnt = $urandom_range(63, 33);
         else if (pick < 10) cnt = 0;
         else if (pick < 14) cnt = 1;
         else cnt = $urandom_range(12, 2);
         set_vertex_count(CNT_W'(cnt));
         n = (cnt > 32) ? 32 : cnt;
         runs = $urandom_range(3, 1);
         repeat (runs) begin
            if (sent >= ITEM_TARGET) break;
            pick = $urandom_range(9, 0);
            if (pick < 7) begin
               style = row_style_type'($urandom_range(5, 0));
               for (src = 0; src < n; src++) send_item(load_item(src, make_row(style, src, n)));
            end else if (pick < 9) begin
               repeat ($urandom_range(4, 1))
                  send_item(load_item($urandom_range(31, 0), $urandom));
            end
            send_item(run_item());
            if (!calm && $urandom_range(7, 0) == 0) wait_idle();
         end
      end
   endtask

   // Compare each result transaction with the oldest expected one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (finish_q.size() == 0) begin
            $error("result with nothing expected: vertex %0d", rsp_data.vertex);
            errors++;
         end else begin
            want = finish_q.pop_front();
            if (rsp_data.vertex !== want.vertex) begin
               $error("vertex: expected %0d, got %0d", want.vertex, rsp_data.vertex);
               errors++;
            end
            if (rsp_data.empty_res !== want.empty_res) begin
               $error("empty_res: expected %0b, got %0b", want.empty_res, rsp_data.empty_res);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   initial begin
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_row_loads();
      test_reset_count_run();
      test_empty_runs();
      test_self_loop();
      test_chain_order();
      test_dense_graph();
      test_count_saturation();
      test_random_graphs();
      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // Watchdog
   initial begin
      #60_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/dfs_fo_pkg.sv
rtl/core/dfs_fo_emit.sv
rtl/core/dfs_finish_order_top.sv
bench/dfs_finish_order_tb.sv
